// File: rtl/wma_pkg.sv
package wma_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 16;
    localparam int NUM_WEIGHTS = 8;
    localparam int WIDX_W      = $clog2(NUM_WEIGHTS);
    localparam int CFG_INDEX_W = 4;
    localparam int PROD_W      = SAMPLE_W + WEIGHT_W;
    // Eight products plus the rounding bias, with headroom
    localparam int ACC_W       = PROD_W + 4;

    // Q1.15 rounding: add half an LSB, then shift by the fraction width
    localparam int ROUND_SHIFT = 15;
    localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    localparam weight_t WEIGHT_RESET = 16'sd4096;
    localparam sample_t SAMPLE_MAX   = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN   = 16'sh8000;

    // Pipeline control handed to the datapath stages
    typedef struct packed {
        logic advance;  // whole pipeline moves one stage
        logic load;     // a new sample transfer is taken this cycle
    } pipe_ctrl_t;

endpackage

// File: rtl/weighted_moving_average_unit.sv
// Weighted moving average over the last TAPS samples with Q1.15 weights.
// A sample is registered in the tap window, then in the products register, then in the result register.
// Throughput: one sample per cycle; the three stages stall together only
// when a result is held at the output by m_ready low.
// Reset (aresetn low, synchronous): sample window cleared to zeros,
// all weights set to 4096 (0.125), pipeline emptied.
module weighted_moving_average_unit
    import wma_pkg::*;
#(
    parameter int TAPS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Sample input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sample_t                s_sample_in,
    // Result output
    output logic                   m_valid,
    input  logic                   m_ready,
    output sample_t                m_average_out,
    output logic                   m_saturated,
    // Weight writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WEIGHT_W-1:0]    cfg_data
);

    weight_t [NUM_WEIGHTS-1:0] weight_reg;

    pipe_ctrl_t         ctrl;
    sample_t [TAPS-1:0] taps;
    prod_t   [TAPS-1:0] prods;
    sample_t            average;
    logic               saturated;

    logic    valid_a_reg;
    logic    valid_b_reg;
    logic    m_valid_reg;
    sample_t m_average_out_reg;
    logic    m_saturated_reg;

    // Pipeline moves whenever the output register is free or being drained
    assign ctrl.advance = !m_valid_reg || m_ready;
    assign ctrl.load    = s_valid && ctrl.advance;
    assign s_ready      = ctrl.advance;

    // Weight registers; writes past the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
                weight_reg[i] <= WEIGHT_RESET;
            end
        end else if (cfg_valid && (cfg_index < CFG_INDEX_W'(NUM_WEIGHTS))) begin
            weight_reg[cfg_index[WIDX_W-1:0]] <= cfg_data;
        end
    end

    // Datapath stages
    wma_taps #(
        .TAPS(TAPS)
    ) u_taps (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .sample_in (s_sample_in),
        .taps      (taps)
    );

    wma_products #(
        .TAPS(TAPS)
    ) u_products (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .taps    (taps),
        .weights (weight_reg),
        .prods   (prods)
    );

    wma_reduce #(
        .TAPS(TAPS)
    ) u_reduce (
        .prods     (prods),
        .average   (average),
        .saturated (saturated)
    );

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (ctrl.advance) begin
            valid_a_reg <= s_valid;
            valid_b_reg <= valid_a_reg;
            m_valid_reg <= valid_b_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            m_average_out_reg <= average;
            m_saturated_reg   <= saturated;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_average_out = m_average_out_reg;
    assign m_saturated   = m_saturated_reg;

`ifndef SYNTHESIS
    // A sample transfer always lands in the first stage
    a_load_to_stage_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_a_reg)
        else $error("accepted sample not tracked in first stage");

    // A stalled pipeline keeps its in-flight items
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.advance |=> ($stable(valid_a_reg) && $stable(valid_b_reg)))
        else $error("pipeline valids moved during stall");

    // A clipped result sits at one of the range limits
    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_average_out == SAMPLE_MAX || m_average_out == SAMPLE_MIN))
        else $error("saturated flag set on an in-range result");

    // A weight write in range updates the addressed register
    a_weight_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && cfg_index < CFG_INDEX_W'(NUM_WEIGHTS)) |=>
            (weight_reg[$past(cfg_index[WIDX_W-1:0])] == $past(cfg_data)))
        else $error("weight write lost");
`endif

endmodule

// File: rtl/wma_taps.sv
module wma_taps
    import wma_pkg::*;
#(
    parameter int TAPS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pipe_ctrl_t           ctrl,
    input  sample_t              sample_in,
    output sample_t [TAPS-1:0]   taps
);

    sample_t [TAPS-1:0] taps_reg;
    sample_t [TAPS-1:0] taps_next;

    // Newest sample enters at tap 0, the oldest drops off the end
    always_comb begin
        taps_next    = taps_reg;
        taps_next[0] = sample_in;
        for (int k = 1; k < TAPS; k++) begin
            taps_next[k] = taps_reg[k-1];
        end
    end

    // Window starts out as all zeros
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_reg <= '0;
        end else if (ctrl.load) begin
            taps_reg <= taps_next;
        end
    end

    assign taps = taps_reg;

endmodule

// File: rtl/wma_products.sv
module wma_products
    import wma_pkg::*;
#(
    parameter int TAPS = 8
) (
    input  logic                         aclk,
    input  pipe_ctrl_t                   ctrl,
    input  sample_t [TAPS-1:0]           taps,
    input  weight_t [NUM_WEIGHTS-1:0]    weights,
    output prod_t   [TAPS-1:0]           prods
);

    prod_t [TAPS-1:0] prod_reg;
    prod_t [TAPS-1:0] prod_next;

    // One 16x16 signed multiplier per tap, weight k on the sample k steps back
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            prod_next[k] = prod_t'(taps[k]) * prod_t'(weights[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            prod_reg <= prod_next;
        end
    end

    assign prods = prod_reg;

endmodule

// File: rtl/wma_reduce.sv
module wma_reduce
    import wma_pkg::*;
#(
    parameter int TAPS = 8
) (
    input  prod_t [TAPS-1:0] prods,
    output sample_t          average,
    output logic             saturated
);

    acc_t sum;
    acc_t scaled;

    // Sum of products in Q.15, exact
    always_comb begin
        sum = '0;
        for (int k = 0; k < TAPS; k++) begin
            sum = sum + acc_t'(prods[k]);
        end
    end

    // Round half up, floor shift back to sample scale
    assign scaled = (sum + acc_t'(ROUND_HALF)) >>> ROUND_SHIFT;

    // Clip to the 16-bit sample range
    always_comb begin
        if (scaled > acc_t'(SAMPLE_MAX)) begin
            average   = SAMPLE_MAX;
            saturated = 1'b1;
        end else if (scaled < acc_t'(SAMPLE_MIN)) begin
            average   = SAMPLE_MIN;
            saturated = 1'b1;
        end else begin
            average   = sample_t'(scaled);
            saturated = 1'b0;
        end
    end

endmodule
